// ===== hw/rtl/keyed_stack_with_move_counts_assert.svh =====
// Assertion macros for the keyed stack with move counts.
`ifndef KEYED_STACK_WITH_MOVE_COUNTS_ASSERT_SVH
`define KEYED_STACK_WITH_MOVE_COUNTS_ASSERT_SVH

// Check prop at every clock edge outside reset.
`define KSMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cond implies prop in the following cycle.
`define KSMC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/ksmc_pkg.sv =====
// Shared types and constants for the keyed stack with move counts.
package ksmc_pkg;

  localparam int KEY_W = 56;
  localparam int STATUS_W = 3;
  localparam int OCC_W = 4;
  localparam int STACK_DEPTH_DEF = 10;
  localparam int COUNT_WIDTH_DEF = 16;

  typedef enum logic {
    CMD_PUSH   = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_MISSING = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic             push_en;
    logic             remove_en;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/keyed_stack_with_move_counts.sv =====
// Keyed stack with move counts: accepted start -> S_EXEC -> registered result strobe.
// Start is taken only in S_IDLE; busy is high in S_EXEC, the compare-and-update state.
// All cells compare the key combinationally and shift down at the same clock edge.
// The result strobe valid_o is high for one cycle; the receiver cannot stall.
// Reset clears the fill level (stack empty) and control; slot contents are not cleared.
module keyed_stack_with_move_counts import ksmc_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cmd_i,
  input  logic [KEY_W-1:0]    plate_key_i,
  output logic                valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [OCC_W-1:0]    occupancy_o
);

  localparam int FILL_W = $clog2(STACK_DEPTH + 1);

  state_e                 state_q, state_d;
  logic                   cmd_q;
  logic [KEY_W-1:0]       key_q;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic                   valid_q, valid_d;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic [OCC_W-1:0]       occ_q, occ_d;
  logic                   accept;
  logic                   any_match;
  logic                   push_ok;
  logic                   remove_ok;
  cell_ctrl_t             ctrl;
  logic [STACK_DEPTH:0]   shift_c;
  logic [KEY_W-1:0]       key_c [STACK_DEPTH];
  logic [COUNT_WIDTH-1:0] cnt_c [STACK_DEPTH];

  assign accept    = start && !busy;
  assign shift_c[0] = 1'b0;
  assign any_match = shift_c[STACK_DEPTH];

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0]       up_key;
    logic [COUNT_WIDTH-1:0] up_cnt;
    if (g + 1 < STACK_DEPTH) begin : g_up
      assign up_key = key_c[g+1];
      assign up_cnt = cnt_c[g+1];
    end else begin : g_top
      assign up_key = '0;
      assign up_cnt = '0;
    end
    ksmc_cell #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .FILL_W     (FILL_W),
      .IDX        (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .fill_i  (fill_q),
      .up_key_i(up_key),
      .up_cnt_i(up_cnt),
      .shift_i (shift_c[g]),
      .key_o   (key_c[g]),
      .cnt_o   (cnt_c[g]),
      .shift_o (shift_c[g+1])
    );
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    valid_d   = 1'b0;
    status_d  = status_q;
    occ_d     = occ_q;
    busy      = 1'b0;
    push_ok   = 1'b0;
    remove_ok = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        busy    = 1'b1;
        valid_d = 1'b1;
        state_d = S_IDLE;
        if (cmd_q == CMD_PUSH) begin
          if (fill_q == FILL_W'(STACK_DEPTH)) begin
            status_d = ST_FULL;
          end else if (any_match) begin
            status_d = ST_DUP;
          end else begin
            status_d = ST_OK;
            push_ok  = 1'b1;
            fill_d   = fill_q + 1'b1;
          end
        end else begin
          if (fill_q == '0) begin
            status_d = ST_EMPTY;
          end else if (!any_match) begin
            status_d = ST_MISSING;
          end else begin
            status_d  = ST_OK;
            remove_ok = 1'b1;
            fill_d    = fill_q - 1'b1;
          end
        end
        occ_d = OCC_W'(fill_d);
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ctrl = '{push_en: push_ok, remove_en: remove_ok, key: key_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      key_q <= plate_key_i;
    end
    status_q <= status_d;
    occ_q    <= occ_d;
  end

  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

  `include "keyed_stack_with_move_counts_assert.svh"

  `KSMC_ASSERT(a_fill_bound, fill_q <= FILL_W'(STACK_DEPTH), "fill level above depth")
  `KSMC_ASSERT_NEXT(a_exec_strobe, state_q == S_EXEC, valid_o && !busy, "no result after exec")
  `KSMC_ASSERT_NEXT(a_push_fill, push_ok, fill_q == $past(fill_q) + 1'b1, "push fill mismatch")
  `KSMC_ASSERT(a_single_op, !(push_ok && remove_ok), "push and remove together")

endmodule

// ===== hw/rtl/ksmc_cell.sv =====
// One stack slot: key, move counter, key compare and shift-down from its upper neighbor.
module ksmc_cell import ksmc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int FILL_W      = 4,
  parameter int IDX         = 0
) (
  input  logic                   clk_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic [FILL_W-1:0]      fill_i,
  input  logic [KEY_W-1:0]       up_key_i,
  input  logic [COUNT_WIDTH-1:0] up_cnt_i,
  input  logic                   shift_i,
  output logic [KEY_W-1:0]       key_o,
  output logic [COUNT_WIDTH-1:0] cnt_o,
  output logic                   shift_o
);

  logic [KEY_W-1:0]       key_q, key_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   live;
  logic                   match;
  logic                   has_upper;

  assign live      = fill_i > FILL_W'(IDX);
  assign has_upper = fill_i > FILL_W'(IDX + 1);
  assign match     = live && (key_q == ctrl_i.key);
  assign shift_o   = shift_i | match;

  always_comb begin
    key_d = key_q;
    cnt_d = cnt_q;
    if (ctrl_i.push_en && (fill_i == FILL_W'(IDX))) begin
      key_d = ctrl_i.key;
      cnt_d = '0;
    end else if (ctrl_i.remove_en && shift_o && has_upper) begin
      key_d = up_key_i;
      cnt_d = (&up_cnt_i) ? up_cnt_i : up_cnt_i + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cnt_q <= cnt_d;
  end

  assign key_o = key_q;
  assign cnt_o = cnt_q;

endmodule
